>>> hw/rtl/wpm_pkg.sv
// ============================================================================
// Wildcard pattern matcher package
// Shared constants, payload structs, queue operation and state types.
// ============================================================================
package wpm_pkg;

    localparam int MAX_PATTERN = 256;
    localparam int ADDR_W      = $clog2(MAX_PATTERN);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ANY  = 8'h3F;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] symbol;
        logic       last;
    } item_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } result_t;

    typedef enum logic {
        OP_WRITE,
        OP_TEXT
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [7:0]       symbol;
        logic             last;
        logic             first;
        logic             overflow;
        logic [LEN_W-1:0] pos;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_port_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SWEEP,
        B_DRAIN,
        B_EMIT
    } back_state_t;

endpackage

>>> hw/rtl/wildcard_pattern_match.sv
// ============================================================================
// Wildcard pattern matcher
// Matches a whole text against a pattern with '?' and '*' wildcards.
// ============================================================================
// The front end accepts one item per cycle while its four-entry operation
// queue has room. In the back end a stored pattern byte is one write to the
// pattern store, and a pattern byte beyond the store is dropped in the front
// end. For a loaded pattern length of one or more, a text byte sweeps the
// reachable position set one pattern position per cycle through the single
// read port of the pattern store; an empty pattern needs no sweep. The last
// byte of a text places the result in the output register once that register
// is no longer stalled. No clearing pass runs after reset.
module wildcard_pattern_match
    import wpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item_data,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    q_port_t queue_wr;
    q_port_t queue_rd;
    logic    queue_full;
    logic    pop;

    wpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .queue_full (queue_full),
        .queue_wr   (queue_wr)
    );

    wpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .queue_wr   (queue_wr),
        .queue_full (queue_full),
        .queue_rd   (queue_rd),
        .pop        (pop)
    );

    wpm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_rd     (queue_rd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

>>> hw/rtl/wpm_front.sv
// ============================================================================
// Wildcard pattern matcher front end
// Accepts items, tracks pattern and text framing, and queues operations.
// ============================================================================
module wpm_front
    import wpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item_data,
    input  logic    queue_full,
    output q_port_t queue_wr
);

    logic             pat_open_reg, pat_open_next;
    logic             text_open_reg, text_open_next;
    logic             ovf_reg, ovf_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] len_base;
    logic             ovf_base;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_open_reg  <= 1'b0;
            text_open_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            len_reg       <= '0;
        end
        else
        begin
            pat_open_reg  <= pat_open_next;
            text_open_reg <= text_open_next;
            ovf_reg       <= ovf_next;
            len_reg       <= len_next;
        end
    end

    always_comb
    begin
        item_stall     = queue_full;
        accept         = item_valid && !queue_full;
        len_base       = pat_open_reg ? len_reg : '0;
        ovf_base       = pat_open_reg ? ovf_reg : 1'b0;
        pat_open_next  = pat_open_reg;
        text_open_next = text_open_reg;
        ovf_next       = ovf_reg;
        len_next       = len_reg;

        queue_wr.valid       = 1'b0;
        queue_wr.op.kind     = OP_TEXT;
        queue_wr.op.symbol   = item_data.symbol;
        queue_wr.op.last     = item_data.last;
        queue_wr.op.first    = !text_open_reg;
        queue_wr.op.overflow = ovf_reg;
        queue_wr.op.pos      = len_reg;

        if (accept)
        begin
            if (item_data.cmd == CMD_PATTERN)
            begin
                text_open_next = 1'b0;
                pat_open_next  = !item_data.last;
                if (len_base < LEN_W'(MAX_PATTERN))
                begin
                    queue_wr.valid   = 1'b1;
                    queue_wr.op.kind = OP_WRITE;
                    queue_wr.op.pos  = len_base;
                    len_next         = len_base + LEN_W'(1);
                    ovf_next         = ovf_base;
                end
                else
                begin
                    len_next = len_base;
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                queue_wr.valid = 1'b1;
                text_open_next = !item_data.last;
            end
        end
    end

endmodule

>>> hw/rtl/wpm_queue.sv
// ============================================================================
// Wildcard pattern matcher operation queue
// Small FIFO that decouples the front end from the matching back end.
// ============================================================================
module wpm_queue
    import wpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_port_t queue_wr,
    output logic    queue_full,
    output q_port_t queue_rd,
    input  logic    pop
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    always_ff @(posedge clk)
    begin
        if (queue_wr.valid)
        begin
            entry_reg[wr_ptr_reg] <= queue_wr.op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        queue_full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
        queue_rd.valid = (count_reg != '0);
        queue_rd.op    = entry_reg[rd_ptr_reg];
        do_pop         = pop && queue_rd.valid;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;

        if (queue_wr.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (queue_wr.valid && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!queue_wr.valid && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    a_no_push_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        queue_wr.valid |-> !queue_full
    ) else $error("Operation pushed into a full queue.");

endmodule

>>> hw/rtl/wpm_back.sv
// ============================================================================
// Wildcard pattern matcher back end
// Holds the pattern store and sweeps the reachable position set per text byte.
// ============================================================================
module wpm_back
    import wpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_port_t queue_rd,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    logic [7:0]        pat_mem   [MAX_PATTERN];
    logic              reach_mem [MAX_PATTERN];
    logic [7:0]        pat_rd_reg;
    logic              reach_rd_reg;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic              proc_valid_reg, proc_valid_next;
    logic [ADDR_W-1:0] proc_pos_reg;
    logic              carry_reg, carry_next;
    logic              run_reg, run_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;

    logic [7:0]        sym_reg;
    logic              last_reg;
    logic              first_reg;
    logic              ovf_reg;
    logic [LEN_W-1:0]  len_reg;

    logic              load_op;
    logic              pat_we;
    logic              reach_we;
    logic              reach_wdata;
    logic              is_star;
    logic              is_hit;
    logic              cur_bit;
    logic              carry_out;

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[queue_rd.op.pos[ADDR_W-1:0]] <= queue_rd.op.symbol;
        end
        pat_rd_reg <= pat_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (reach_we)
        begin
            reach_mem[proc_pos_reg] <= reach_wdata;
        end
        reach_rd_reg <= reach_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        proc_pos_reg <= pos_reg;
        out_data_reg <= out_data_next;
        if (load_op)
        begin
            sym_reg   <= queue_rd.op.symbol;
            last_reg  <= queue_rd.op.last;
            first_reg <= queue_rd.op.first;
            ovf_reg   <= queue_rd.op.overflow;
            len_reg   <= queue_rd.op.pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pos_reg        <= '0;
            proc_valid_reg <= 1'b0;
            carry_reg      <= 1'b0;
            run_reg        <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            proc_valid_reg <= proc_valid_next;
            carry_reg      <= carry_next;
            run_reg        <= run_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        is_star     = (pat_rd_reg == SYM_STAR);
        is_hit      = (pat_rd_reg == SYM_ANY) || (pat_rd_reg == sym_reg);
        cur_bit     = first_reg ? run_reg : reach_rd_reg;
        reach_wdata = carry_reg | (cur_bit & is_star);
        carry_out   = (cur_bit & !is_star & is_hit) | (reach_wdata & is_star);
        reach_we    = proc_valid_reg;

        carry_next = carry_reg;
        run_next   = run_reg;
        if (proc_valid_reg)
        begin
            carry_next = carry_out;
            run_next   = run_reg & is_star;
        end

        state_next      = state_reg;
        pos_next        = pos_reg;
        proc_valid_next = (state_reg == B_SWEEP);
        pop             = 1'b0;
        pat_we          = 1'b0;
        load_op         = 1'b0;
        out_valid_next  = out_valid_reg && result_stall;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (queue_rd.valid)
                begin
                    pop = 1'b1;
                    if (queue_rd.op.kind == OP_WRITE)
                    begin
                        pat_we = 1'b1;
                    end
                    else
                    begin
                        load_op    = 1'b1;
                        pos_next   = '0;
                        carry_next = 1'b0;
                        run_next   = 1'b1;
                        if (queue_rd.op.pos == '0)
                        begin
                            state_next = queue_rd.op.last ? B_EMIT : B_IDLE;
                        end
                        else
                        begin
                            state_next = B_SWEEP;
                        end
                    end
                end
            end
            B_SWEEP:
            begin
                pos_next = pos_reg + ADDR_W'(1);
                if ({1'b0, pos_reg} == len_reg - LEN_W'(1))
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                state_next = last_reg ? B_EMIT : B_IDLE;
            end
            B_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.matched  = carry_reg;
                    out_data_next.overflow = ovf_reg;
                    state_next             = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    a_sweep_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == B_SWEEP) |-> ({1'b0, pos_reg} < len_reg)
    ) else $error("Sweep position ran past the pattern length.");

    a_proc_in_sweep: assert property (
        @(posedge clk) disable iff (!rst_n)
        proc_valid_reg |-> (state_reg == B_SWEEP || state_reg == B_DRAIN)
    ) else $error("Position update outside of a sweep.");

    a_emit_on_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT) |-> last_reg
    ) else $error("Result pending for a text byte that is not the last.");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Wildcard pattern matcher testbench
// Loads patterns that contain '?' and '*' and streams texts through the
// matcher. A behavioral model keeps the set of reachable pattern positions
// and predicts each match result. Both sides of the block idle at random.
// The receiver holds off long enough to back the block up, and the sender
// pauses twice until all results have drained.
// ============================================================================
module tb_top
    import wpm_pkg::*;
();

    localparam logic [MAX_PATTERN:0] START_ONLY = {{MAX_PATTERN{1'b0}}, 1'b1};

    typedef struct {
        item_t item;
        int    gap;
        bit    drain_first;
    } pending_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item_data = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result_data;

    wildcard_pattern_match dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always #5 clk = ~clk;

    // Matcher model state.
    logic [7:0]           pat_bytes [MAX_PATTERN];
    int                   pat_len;
    logic [MAX_PATTERN:0] reach;
    bit                   pat_open;
    bit                   txt_open;
    bit                   pat_over;

    pending_t    pending_transfers [$];
    result_t     expected_results [$];
    int          outstanding = 0;
    int          accepted_count = 0;
    int          n_queued = 0;
    longint      budget = 0;
    longint      cycle_limit = 64'd1000000000;
    longint      cycle_count = 0;
    int          mismatches = 0;

    // Stimulus generation state.
    logic [7:0]  gen_pat [$];
    logic [7:0]  gen_txt [$];
    int          gen_len = 0;
    bit          gen_open = 1'b0;
    bit          gen_long = 1'b0;
    int          tx_idle_pct = 30;
    bit          drain_next = 1'b0;

    // Driver and receiver private state.
    int          tx_wait = 0;
    bit          gap_loaded = 1'b0;
    int          rx_wait = 0;
    int          rx_hold = 0;
    int          results_seen = 0;

    // Run statistics.
    int          pattern_bytes = 0;
    int          text_bytes = 0;
    int          matched_ones = 0;
    int          overflow_ones = 0;
    int          stall_cycles = 0;

    function automatic logic [MAX_PATTERN:0] star_closure(input logic [MAX_PATTERN:0] s);
        for (int j = 0; j < pat_len; j++)
        begin
            if (s[j] && pat_bytes[j] == SYM_STAR)
                s[j + 1] = 1'b1;
        end
        return s;
    endfunction

    task automatic clear_matcher();
        pat_len  = 0;
        pat_open = 1'b0;
        txt_open = 1'b0;
        pat_over = 1'b0;
        reach    = star_closure(START_ONLY);
    endtask

    task automatic step_matcher(input item_t it, output bit has_res, output result_t res);
        logic [MAX_PATTERN:0] nxt;
        has_res = 1'b0;
        res     = '0;
        if (it.cmd == CMD_PATTERN)
        begin
            txt_open = 1'b0;
            if (!pat_open)
            begin
                pat_len  = 0;
                pat_over = 1'b0;
                pat_open = 1'b1;
            end
            if (pat_len < MAX_PATTERN)
            begin
                pat_bytes[pat_len] = it.symbol;
                pat_len++;
            end
            else
                pat_over = 1'b1;
            if (it.last)
                pat_open = 1'b0;
            reach = star_closure(START_ONLY);
            return;
        end
        if (!txt_open)
        begin
            reach    = star_closure(START_ONLY);
            txt_open = 1'b1;
        end
        nxt = '0;
        for (int j = 0; j < pat_len; j++)
        begin
            if (reach[j])
            begin
                if (pat_bytes[j] == SYM_STAR)
                    nxt[j] = 1'b1;
                else if (pat_bytes[j] == SYM_ANY || pat_bytes[j] == it.symbol)
                    nxt[j + 1] = 1'b1;
            end
        end
        reach = star_closure(nxt);
        if (it.last)
        begin
            has_res      = 1'b1;
            res.matched  = reach[pat_len];
            res.overflow = pat_over;
            txt_open     = 1'b0;
            reach        = star_closure(START_ONLY);
        end
    endtask

    function automatic logic [7:0] pick_symbol(input bit wild);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (wild && r < 2)
            return SYM_STAR;
        if (wild && r == 2)
            return SYM_ANY;
        if (r < 7)
            return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    // Queues one transfer and adds its worst-case cost to the cycle budget.
    task automatic queue_item(input logic cmd, input logic [7:0] sym, input logic last);
        pending_t e;
        e.item.cmd    = cmd;
        e.item.symbol = sym;
        e.item.last   = last;
        e.gap         = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 16) : 0;
        e.drain_first = drain_next;
        drain_next    = 1'b0;
        pending_transfers.push_back(e);
        n_queued++;
        if (cmd == CMD_PATTERN)
        begin
            if (!gen_open)
                gen_len = 0;
            gen_open = !last;
            if (gen_len < MAX_PATTERN)
                gen_len++;
            budget += 18;
        end
        else
            budget += 20 + gen_len + (last ? 17 : 0);
    endtask

    task automatic feed_str(input string s);
        for (int k = 0; k < s.len(); k++)
            queue_item(CMD_TEXT, s[k], k == s.len() - 1);
    endtask

    task automatic make_pattern();
        int n;
        gen_pat.delete();
        case ($urandom_range(0, 99)) inside
            [0:69]:  n = $urandom_range(1, 6);
            [70:94]: n = $urandom_range(7, 24);
            [95:98]: n = $urandom_range(25, 64);
            default: n = $urandom_range(200, 300);
        endcase
        gen_long = n > 64;
        for (int k = 0; k < n; k++)
        begin
            if (gen_long)
                gen_pat.push_back(($urandom_range(0, 9) != 0) ? SYM_STAR : pick_symbol(1));
            else
                gen_pat.push_back(pick_symbol(1));
        end
    endtask

    task automatic make_text();
        int pos;
        gen_txt.delete();
        if (gen_long)
        begin
            repeat ($urandom_range(1, 4))
                gen_txt.push_back(pick_symbol(0));
            return;
        end
        foreach (gen_pat[k])
        begin
            if (gen_pat[k] == SYM_STAR)
            begin
                repeat ($urandom_range(0, 2))
                    gen_txt.push_back(pick_symbol(0));
            end
            else if (gen_pat[k] == SYM_ANY)
                gen_txt.push_back(8'($urandom_range(0, 255)));
            else
                gen_txt.push_back(gen_pat[k]);
        end
        if ($urandom_range(0, 99) < 30 && gen_txt.size() != 0)
        begin
            pos = $urandom_range(0, gen_txt.size() - 1);
            case ($urandom_range(0, 2))
                0:       gen_txt[pos] = pick_symbol(0);
                1:       gen_txt.delete(pos);
                default: gen_txt.insert(pos, pick_symbol(0));
            endcase
        end
        while (gen_txt.size() > 24)
            void'(gen_txt.pop_back());
        if (gen_txt.size() == 0)
            gen_txt.push_back(pick_symbol(0));
    endtask

    task automatic send_pattern(input int from, input int upto);
        for (int k = from; k < upto; k++)
            queue_item(CMD_PATTERN, gen_pat[k], k == gen_pat.size() - 1);
    endtask

    task automatic send_text(input bit close);
        foreach (gen_txt[k])
            queue_item(CMD_TEXT, gen_txt[k], close && k == gen_txt.size() - 1);
    endtask

    task automatic load_and_test();
        make_pattern();
        send_pattern(0, gen_pat.size());
        repeat ($urandom_range(1, 4))
        begin
            make_text();
            send_text(1'b1);
        end
    endtask

    // Sender: each transfer waits out its own gap after the previous one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_data  <= '0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (pending_transfers.size() != 0 && !gap_loaded)
            begin
                tx_wait    = pending_transfers[0].gap;
                gap_loaded = 1'b1;
            end
            if (pending_transfers.size() == 0)
                item_valid <= 1'b0;
            else if (tx_wait > 0)
            begin
                tx_wait--;
                item_valid <= 1'b0;
            end
            else if (pending_transfers[0].drain_first && (outstanding != 0 || item_valid))
                item_valid <= 1'b0;
            else
            begin
                item_valid <= 1'b1;
                item_data  <= pending_transfers[0].item;
                void'(pending_transfers.pop_front());
                gap_loaded = 1'b0;
            end
        end
    end

    // Receiver: a random stall after each result except in every third run of twenty results, and two long hold-offs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                rx_wait = ((results_seen / 20) % 3 == 0) ? 0 : $urandom_range(0, 16);
                if (results_seen == 40 || results_seen == 150)
                    rx_hold = 400;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                result_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Scoreboard: predicts on each input transfer and checks each result transfer.
    always @(posedge clk)
    begin
        bit      has_res;
        result_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                step_matcher(item_data, has_res, want);
                if (has_res)
                    expected_results.push_back(want);
                if (item_data.cmd == CMD_PATTERN)
                    pattern_bytes++;
                else
                    text_bytes++;
                accepted_count <= accepted_count + 1;
            end
            if (item_valid && item_stall)
                stall_cycles++;
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: matched=%0b overflow=%0b",
                                 result_data.matched, result_data.overflow);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_data.matched !== want.matched
                        || result_data.overflow !== want.overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %0b/%0b, got %0b/%0b (matched/overflow)",
                                     want.matched, want.overflow,
                                     result_data.matched, result_data.overflow);
                    end
                    matched_ones  += want.matched;
                    overflow_ones += want.overflow;
                end
            end
            outstanding <= expected_results.size();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int seq_idx;
        int kind;
        int split;
        clear_matcher();

        // Directed part.
        queue_item(CMD_TEXT, "a", 1'b1);
        queue_item(CMD_PATTERN, SYM_STAR, 1'b1);
        queue_item(CMD_TEXT, 8'h00, 1'b1);
        queue_item(CMD_PATTERN, 8'hFF, 1'b0);
        queue_item(CMD_PATTERN, SYM_ANY, 1'b0);
        queue_item(CMD_PATTERN, SYM_STAR, 1'b0);
        queue_item(CMD_PATTERN, 8'h00, 1'b1);
        queue_item(CMD_TEXT, 8'hFF, 1'b0);
        queue_item(CMD_TEXT, SYM_STAR, 1'b0);
        queue_item(CMD_TEXT, 8'h00, 1'b1);
        queue_item(CMD_TEXT, 8'hFF, 1'b0);
        queue_item(CMD_TEXT, 8'h01, 1'b0);
        queue_item(CMD_TEXT, 8'h7F, 1'b0);
        queue_item(CMD_TEXT, 8'h00, 1'b1);
        queue_item(CMD_TEXT, 8'hFF, 1'b0);
        queue_item(CMD_PATTERN, "a", 1'b0);
        queue_item(CMD_TEXT, "a", 1'b1);
        queue_item(CMD_PATTERN, "b", 1'b1);
        feed_str("ab");
        feed_str("abc");
        feed_str("b");

        // Patterns that overflow the store, and one that fills it exactly.
        queue_item(CMD_PATTERN, "a", 1'b0);
        repeat (255)
            queue_item(CMD_PATTERN, SYM_STAR, 1'b0);
        repeat (43)
            queue_item(CMD_PATTERN, "z", 1'b0);
        queue_item(CMD_PATTERN, "z", 1'b1);
        feed_str("a");
        feed_str("ab");
        feed_str("b");
        repeat (255)
            queue_item(CMD_PATTERN, SYM_STAR, 1'b0);
        queue_item(CMD_PATTERN, SYM_ANY, 1'b1);
        feed_str("q");
        feed_str("qq");
        queue_item(CMD_PATTERN, "b", 1'b0);
        repeat (255)
            queue_item(CMD_PATTERN, SYM_STAR, 1'b0);
        queue_item(CMD_PATTERN, SYM_ANY, 1'b1);
        feed_str("b");

        // Random part.
        seq_idx = 0;
        while (n_queued < 1900)
        begin
            seq_idx++;
            case ($urandom_range(0, 4))
                0, 1:    tx_idle_pct = 0;
                2:       tx_idle_pct = 20;
                3:       tx_idle_pct = 50;
                default: tx_idle_pct = 100;
            endcase
            if (seq_idx == 40 || seq_idx == 160)
                drain_next = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 78)
                load_and_test();
            else if (kind < 86)
            begin
                make_pattern();
                split = (gen_pat.size() > 1) ? $urandom_range(1, gen_pat.size() - 1) : 0;
                send_pattern(0, split);
                make_text();
                send_text(1'b1);
                send_pattern(split, gen_pat.size());
                make_text();
                send_text(1'b1);
            end
            else if (kind < 93)
            begin
                make_text();
                send_text(1'b0);
                load_and_test();
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    make_text();
                    send_text(1'b1);
                end
            end
        end
        cycle_limit = 4 * budget + 2 * 400 + 20000;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count != n_queued)
            @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat ((QUEUE_DEPTH + 2) * (MAX_PATTERN + 3)) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_results.size());
            mismatches += expected_results.size();
        end
        $display("Covered %0d transfers in (%0d pattern bytes, %0d text bytes) and %0d results",
                 accepted_count, pattern_bytes, text_bytes, results_seen);
        $display("Results with a match: %0d, with overflow: %0d; input stalled on %0d cycles",
                 matched_ones, overflow_ones, stall_cycles);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
